/* rtl/rtp_pkg.sv */
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared widths, the arctangent table and the gain helpers of the
// rectangular to polar converter.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // Datapath word: Q.16 coordinate with headroom for the CORDIC growth.
  localparam int XW = 36;
  // Angle accumulator in Q2.30 with room for the left half-plane fold.
  localparam int ZW = 34;
  // Width of the inverse gain constant in Q.30.
  localparam int KW = 30;

  localparam int ATAN_LEN = 24;
  localparam int ANGLE_LIMIT = 25736;

  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;

  // atan(2^-i) in Q2.30, rounded to nearest.
  localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  // Restoring long division, used only while elaborating the gain constant.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Floor integer square root, digit by digit.
  function automatic logic [63:0] isqrt64(logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = val;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Inverse CORDIC gain in Q.30 for the given number of micro-rotations.
  function automatic logic [63:0] gain_q30(int n);
    logic [63:0] k2;
    logic [63:0] den;
    k2 = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      den = (64'd1 << (2 * i)) + 64'd1;
      k2 = k2 - udiv64(k2, den);
    end
    return isqrt64(k2);
  endfunction

endpackage

/* rtl/rect_to_polar_converter_unit.sv */
// ----------------------------------------------------------------------------
// rect_to_polar_converter_unit
// Pipelined CORDIC vectoring converter from (x, y) to magnitude and angle.
// ----------------------------------------------------------------------------
// The unit takes one point per clock unless stalled and returns its rounded
// distance from the origin and its angle atan2(y, x) in radians as signed
// Q3.13. Its stages are one input register that folds the point into the
// right half-plane, one register stage per micro-rotation, one stage that
// unfolds the angle and forms two partial products of the gain multiply,
// and the output register that rounds and saturates the magnitude. The
// inverse gain is a constant worked out at elaboration. Each stage advances
// whenever the stage after it is empty or moving, so a stalled output only
// holds back the stages that are actually full and bubbles are squeezed out.
module rect_to_polar_converter_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_x_coord,
  input  logic [15:0] in_y_coord,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_magnitude,
  output logic [15:0] out_angle_rad
);
  import rtp_pkg::*;

  localparam int N = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [KW-1:0] GAIN = KW'(gain_q30(N));
  localparam int XLO = 18;
  localparam int XHI = XW - 1 - XLO;

  // Stage registers: index 0 is the folded input, index k+1 follows step k.
  logic                 v_r    [0:N];
  logic signed [XW-1:0] x_r    [0:N];
  logic signed [XW-1:0] y_r    [0:N];
  logic signed [ZW-1:0] z_r    [0:N];
  logic                 left_r [0:N];
  logic                 ypos_r [0:N];
  logic                 zero_r [0:N];

  logic [N+1:0] rdy;
  logic         out_rdy;

  logic                  pv_r;
  logic                  pzero_r;
  logic signed [15:0]    pang_r;
  logic [XLO+KW-1:0]     plo_r;
  logic [XHI+KW-1:0]     phi_r;

  logic                  out_valid_r;
  logic [15:0]           out_magnitude_r;
  logic [15:0]           out_angle_rad_r;

  assign out_rdy  = !out_valid_r || !out_stall;
  assign rdy[N+1] = !pv_r || out_rdy;
  assign in_stall = !rdy[0];

  genvar k;
  generate
    for (k = 0; k <= N; k++) begin : g_rdy
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end
  endgenerate

  // Input fold: the CORDIC always runs on (|x|, y).
  logic signed [16:0]    xs;
  logic signed [16:0]    xa;
  logic signed [XW-1:0]  x_nxt0;
  logic signed [XW-1:0]  y_nxt0;

  always_comb begin
    xs = {in_x_coord[15], in_x_coord};
    xa = xs[16] ? -xs : xs;
    x_nxt0 = {{(XW-33){1'b0}}, xa, 16'b0};
    y_nxt0 = {{(XW-32){in_y_coord[15]}}, in_y_coord, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_r[0]    <= x_nxt0;
      y_r[0]    <= y_nxt0;
      z_r[0]    <= '0;
      left_r[0] <= in_x_coord[15];
      ypos_r[0] <= !in_y_coord[15];
      zero_r[0] <= (in_x_coord == 16'd0) && (in_y_coord == 16'd0);
    end
  end

  // One micro-rotation per stage.
  generate
    for (k = 0; k < N; k++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN_K = ZW'(ATAN_Q30[k]);
      logic signed [XW-1:0] x_nxt;
      logic signed [XW-1:0] y_nxt;
      logic signed [ZW-1:0] z_nxt;

      always_comb begin
        if (!y_r[k][XW-1]) begin
          x_nxt = x_r[k] + (y_r[k] >>> k);
          y_nxt = y_r[k] - (x_r[k] >>> k);
          z_nxt = z_r[k] + ATAN_K;
        end else begin
          x_nxt = x_r[k] - (y_r[k] >>> k);
          y_nxt = y_r[k] + (x_r[k] >>> k);
          z_nxt = z_r[k] - ATAN_K;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k+1] <= 1'b0;
        end else if (rdy[k+1]) begin
          v_r[k+1] <= v_r[k];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k+1]) begin
          x_r[k+1]    <= x_nxt;
          y_r[k+1]    <= y_nxt;
          z_r[k+1]    <= z_nxt;
          left_r[k+1] <= left_r[k];
          ypos_r[k+1] <= ypos_r[k];
          zero_r[k+1] <= zero_r[k];
        end
      end
    end
  endgenerate

  // Unfold the angle, round and clamp it to Q3.13 and split the gain multiply in two.
  logic signed [ZW-1:0]  zf;
  logic signed [ZW-1:0]  zrnd;
  logic signed [16:0]    ang17;
  logic signed [15:0]    pang_nxt;
  logic [XW-2:0]         xcl;
  logic [XLO+KW-1:0]     plo_nxt;
  logic [XHI+KW-1:0]     phi_nxt;

  always_comb begin
    if (!left_r[N]) begin
      zf = z_r[N];
    end else if (ypos_r[N]) begin
      zf = PI_Q30 - z_r[N];
    end else begin
      zf = -PI_Q30 - z_r[N];
    end
    zrnd  = zf + ZW'(65536);
    ang17 = zrnd[ZW-1:17];
    if (ang17 > 17'sd25736) begin
      pang_nxt = 16'(ANGLE_LIMIT);
    end else if (ang17 < -17'sd25736) begin
      pang_nxt = -16'(ANGLE_LIMIT);
    end else begin
      pang_nxt = ang17[15:0];
    end
    xcl     = x_r[N][XW-1] ? '0 : x_r[N][XW-2:0];
    plo_nxt = (XLO+KW)'(xcl[XLO-1:0]) * (XLO+KW)'(GAIN);
    phi_nxt = (XHI+KW)'(xcl[XW-2:XLO]) * (XHI+KW)'(GAIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (rdy[N+1]) begin
      pv_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N+1]) begin
      pzero_r <= zero_r[N];
      pang_r  <= pang_nxt;
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
    end
  end

  // Output word: recombine, round half up and saturate the magnitude.
  localparam int SW = XW - 1 + KW + 1;
  logic [SW-1:0] msum;
  logic [SW-47:0] mfull;
  logic [15:0]   mag_nxt;

  always_comb begin
    msum  = {1'b0, phi_r, {XLO{1'b0}}} + SW'(plo_r) + (SW'(1) << 45);
    mfull = msum[SW-1:46];
    if (mfull > (SW-46)'(65535)) begin
      mag_nxt = 16'hFFFF;
    end else begin
      mag_nxt = mfull[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_magnitude_r <= pzero_r ? 16'd0 : mag_nxt;
      out_angle_rad_r <= pzero_r ? 16'd0 : pang_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_magnitude_r;
  assign out_angle_rad = out_angle_rad_r;

  // With the output side empty, every stage can move, so nothing is refused.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // An accepted word must show up in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted word missing from the first stage");

  // The delivered angle never leaves the clamped range.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_angle_rad_r) <= 16'sd25736) &&
                    ($signed(out_angle_rad_r) >= -16'sd25736))
    else $error("angle outside of the -pi..pi range");

endmodule
